// File: design/mfb2oled_pkg.sv
// Shared constants and types for the framebuffer to OLED page formatter.
package mfb2oled_pkg;

  localparam int ROW_BYTES   = 16;
  localparam int PAGES       = 8;
  localparam int BAND_ROWS   = 8;
  localparam int STORED_ROWS = BAND_ROWS - 1;
  localparam int FRAME_ROWS  = PAGES * BAND_ROWS;

  localparam int BYTE_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W  = $clog2(FRAME_ROWS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BAND_W = $clog2(BAND_ROWS);

  localparam int CMD_COUNT   = 3;
  localparam int MAX_RESULTS = CMD_COUNT + 8;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  // One queued result: the byte and the data/command flag.
  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
  } out_item_t;

endpackage

// File: design/mono_framebuffer_to_oled_pages.sv
// Top level: row-major 1-bit framebuffer bytes to OLED page-format byte stream.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+---------------------
//   in      | input     | in_pixel_byte[7:0], in_frame_start      | in_valid / in_stall
//   out     | output    | out_byte[7:0], out_is_data, out_last    | out_valid / out_stall
//
// Bytes of band rows 0 to 6 are written to one of seven row RAMs. A byte of band row 7
// reads the seven row RAMs and waits with the read data; its results enter the queue as
// it empties, then leave one per cycle while the output is not stalled: 8 results, or 11
// at byte 0 of a row (page commands), so a band yields 131 results. rst_n is synchronous
// and clears the counters and valid flags; RAM contents are not cleared. A stalled output
// holds the queue, and the input stalls while a row 7 byte waits and cannot yet load.
module mono_framebuffer_to_oled_pages (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_last
);

  localparam int BYTE_W  = mfb2oled_pkg::BYTE_W;
  localparam int ROW_W   = mfb2oled_pkg::ROW_W;
  localparam int PAGE_W  = mfb2oled_pkg::PAGE_W;
  localparam int BAND_W  = mfb2oled_pkg::BAND_W;
  localparam int COUNT_W = mfb2oled_pkg::COUNT_W;
  localparam int NRES    = mfb2oled_pkg::MAX_RESULTS;
  localparam int NSTORE  = mfb2oled_pkg::STORED_ROWS;
  localparam int NCMD    = mfb2oled_pkg::CMD_COUNT;

  // Position counters.
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  // Row 7 byte held with the RAM read data until the result queue takes it.
  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_pix_r;
  logic              s1_first_r;
  logic [PAGE_W-1:0] s1_page_r;

  // Result queue; entry 0 is on the output.
  mfb2oled_pkg::out_item_t q_r   [NRES];
  mfb2oled_pkg::out_item_t q_nxt [NRES];
  logic [COUNT_W-1:0]      cnt_r, cnt_nxt;

  logic              in_accept;
  logic              pop;
  logic              s1_load;
  logic [ROW_W-1:0]  eff_row;
  logic [BYTE_W-1:0] eff_byte;
  logic [BAND_W-1:0] band_row;
  logic              emit_row;
  logic [7:0]        rd_data [NSTORE];
  logic [7:0]        col [8];

  assign eff_row  = in_frame_start ? '0 : row_r;
  assign eff_byte = in_frame_start ? '0 : byte_r;
  assign band_row = eff_row[BAND_W-1:0];
  assign emit_row = (band_row == BAND_W'(mfb2oled_pkg::BAND_ROWS - 1));

  assign out_valid   = (cnt_r != '0);
  assign out_byte    = q_r[0].value;
  assign out_is_data = q_r[0].is_data;
  assign out_last    = (cnt_r == COUNT_W'(1));

  assign pop       = out_valid && !out_stall;
  assign s1_load   = s1_valid_r && ((cnt_r == '0) || (pop && cnt_r == COUNT_W'(1)));
  assign in_stall  = s1_valid_r && !s1_load;
  assign in_accept = in_valid && !in_stall;

  // One RAM per stored band row, addressed by byte column.
  for (genvar r = 0; r < NSTORE; r++) begin : g_row
    mfb2oled_ram #(
      .WIDTH(8),
      .DEPTH(mfb2oled_pkg::ROW_BYTES)
    ) u_row_ram (
      .clk    (clk),
      .wr_en  (in_accept && (band_row == BAND_W'(r))),
      .wr_addr(eff_byte),
      .wr_data(in_pixel_byte),
      .rd_en  (in_accept && emit_row),
      .rd_addr(eff_byte),
      .rd_data(rd_data[r])
    );
  end

  // Transpose: column byte k gathers bit k of every band row.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int r = 0; r < NSTORE; r++) begin
        col[k][r] = rd_data[r][k];
      end
      col[k][7] = s1_pix_r[k];
    end
  end

  always_comb begin
    row_nxt  = row_r;
    byte_nxt = byte_r;
    if (in_accept) begin
      if (eff_byte == BYTE_W'(mfb2oled_pkg::ROW_BYTES - 1)) begin
        byte_nxt = '0;
        row_nxt  = (eff_row == ROW_W'(mfb2oled_pkg::FRAME_ROWS - 1)) ? '0 : eff_row + 1'b1;
      end else begin
        byte_nxt = eff_byte + 1'b1;
        row_nxt  = eff_row;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_accept && emit_row) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (s1_load) begin
      if (s1_first_r) begin
        q_nxt[0] = '{value: mfb2oled_pkg::CMD_PAGE + 8'(s1_page_r), is_data: 1'b0};
        q_nxt[1] = '{value: mfb2oled_pkg::CMD_COL_LO, is_data: 1'b0};
        q_nxt[2] = '{value: mfb2oled_pkg::CMD_COL_HI, is_data: 1'b0};
        for (int k = 0; k < 8; k++) begin
          q_nxt[NCMD + k] = '{value: col[k], is_data: 1'b1};
        end
        cnt_nxt = COUNT_W'(NRES);
      end else begin
        for (int k = 0; k < 8; k++) begin
          q_nxt[k] = '{value: col[k], is_data: 1'b1};
        end
        cnt_nxt = COUNT_W'(8);
      end
    end else if (pop) begin
      for (int i = 0; i < NRES - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      byte_r     <= '0;
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      row_r      <= row_nxt;
      byte_r     <= byte_nxt;
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (in_accept && emit_row) begin
      s1_pix_r   <= in_pixel_byte;
      s1_first_r <= (eff_byte == '0);
      s1_page_r  <= PAGE_W'(eff_row >> BAND_W);
    end
  end

  // A loaded row 7 byte is on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> out_valid)
    else $error("queue load did not produce a result");

  // The first result of a row is the page address command.
  a_first_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_load && s1_first_r) |=> (!out_is_data && out_byte[7:4] == 4'hB))
    else $error("row start did not begin with page command");

  // The last result of a burst is always a column byte.
  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_is_data)
    else $error("burst ended on a command byte");

  // Input is throttled only by a waiting row 7 byte.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with nothing waiting");

  // Taking the final result without a new load empties the queue.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_last && !s1_load) |=> !out_valid)
    else $error("queue not empty after last result");

endmodule

// File: design/mfb2oled_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfb2oled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
